FILE: rtl/tlvp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and beat layout of the packed element stream parser
package tlvp_pkg;

	// width of the element and value counters
	localparam int COUNT_BITS = 32;

	// largest count that fits the counters, one bit wider than a word
	localparam logic [32:0] CNT_CAP = (33'd1 << COUNT_BITS) - 33'd1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ELEMENTS   = 3'd0,
		REG_INT_TYPE_CODE  = 3'd1,
		REG_STR_TYPE_CODE  = 3'd2,
		REG_DATA_TYPE_CODE = 3'd3,
		REG_BIG_ENDIAN     = 3'd4
	} reg_idx_t;

	// field kind tags
	typedef enum logic [3:0] {
		KIND_COUNT    = 4'd0,
		KIND_NAMELEN  = 4'd1,
		KIND_NAME     = 4'd2,
		KIND_TYPE     = 4'd3,
		KIND_VALCOUNT = 4'd4,
		KIND_INT      = 4'd5,
		KIND_VALLEN   = 4'd6,
		KIND_STRBYTE  = 4'd7,
		KIND_DATABYTE = 4'd8,
		KIND_IGNORED  = 4'd9
	} kind_t;

	// sticky error codes
	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_ZERO_COUNT   = 3'd1,
		ERR_OVER_LIMIT   = 3'd2,
		ERR_ZERO_VALUES  = 3'd3,
		ERR_UNKNOWN_TYPE = 3'd4
	} err_t;

	// configuration register set
	typedef struct packed {
		logic [31:0] max_elements;
		logic [31:0] int_type_code;
		logic [31:0] str_type_code;
		logic [31:0] data_type_code;
		logic        big_endian_words;
	} cfg_t;

	// one result beat before packing
	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       field_kind;
		logic        word_ready;
		logic [31:0] word_value;
		logic [31:0] element_index;
		logic [31:0] value_index;
		logic        field_end;
		logic        element_end;
		logic        parse_done;
		err_t        error_code;
	} res_t;

	// output tdata layout, lowest bit up
	localparam int OUT_W     = 112;
	localparam int POS_BYTE  = 0;
	localparam int POS_WRDY  = 8;
	localparam int POS_WVAL  = 9;
	localparam int POS_EIDX  = 41;
	localparam int POS_VIDX  = 73;
	localparam int POS_FEND  = 105;
	localparam int POS_EEND  = 106;
	localparam int POS_DONE  = 107;
	localparam int POS_ERR   = 108;

endpackage

FILE: rtl/tlvp_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file of the stream parser
module tlvp_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [tlvp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	output tlvp_pkg::cfg_t                    cfg
);
	import tlvp_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_elements     <= 32'd0;
			cfg_q.int_type_code    <= 32'd0;
			cfg_q.str_type_code    <= 32'd1;
			cfg_q.data_type_code   <= 32'd2;
			cfg_q.big_endian_words <= 1'b0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_ELEMENTS:   cfg_q.max_elements     <= cfg_data;
				REG_INT_TYPE_CODE:  cfg_q.int_type_code    <= cfg_data;
				REG_STR_TYPE_CODE:  cfg_q.str_type_code    <= cfg_data;
				REG_DATA_TYPE_CODE: cfg_q.data_type_code   <= cfg_data;
				REG_BIG_ENDIAN:     cfg_q.big_endian_words <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/tlvp_parse_core.sv
`timescale 1ns / 1ps
// parse state and per-byte tagging logic
module tlvp_parse_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     in_byte,
	input  tlvp_pkg::cfg_t cfg,
	output tlvp_pkg::res_t res
);
	import tlvp_pkg::*;

	typedef enum logic [3:0] {
		PH_COUNT    = 4'd0,
		PH_NAMELEN  = 4'd1,
		PH_NAME     = 4'd2,
		PH_TYPE     = 4'd3,
		PH_VALCOUNT = 4'd4,
		PH_INT      = 4'd5,
		PH_VALLEN   = 4'd6,
		PH_VALUE    = 4'd7,
		PH_DONE     = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		CLS_INT     = 2'd0,
		CLS_STR     = 2'd1,
		CLS_DATA    = 2'd2,
		CLS_UNKNOWN = 2'd3
	} cls_t;

	phase_t                phase_q, phase_d;
	logic [1:0]            pos_q, pos_d;
	logic [31:0]           shift_q, shift_d;
	logic [COUNT_BITS-1:0] el_total_q, el_total_d;
	logic [COUNT_BITS-1:0] el_seen_q, el_seen_d;
	logic [COUNT_BITS-1:0] val_total_q, val_total_d;
	logic [COUNT_BITS-1:0] val_seen_q, val_seen_d;
	logic [31:0]           remain_q, remain_d;
	cls_t                  cls_q, cls_d;
	err_t                  err_q, err_d;

	// next state and result for the byte in hand
	always_comb begin
		logic [31:0]           w;
		logic [31:0]           rem_dec;
		logic [COUNT_BITS-1:0] vs_inc;
		logic [COUNT_BITS-1:0] es_inc;
		logic                  fin;

		w       = cfg.big_endian_words ? {shift_q[23:0], in_byte} : {in_byte, shift_q[31:8]};
		rem_dec = remain_q - 32'd1;
		vs_inc  = val_seen_q + COUNT_BITS'(1);
		es_inc  = el_seen_q + COUNT_BITS'(1);
		fin     = 1'b0;

		phase_d     = phase_q;
		pos_d       = pos_q;
		shift_d     = shift_q;
		el_total_d  = el_total_q;
		el_seen_d   = el_seen_q;
		val_total_d = val_total_q;
		val_seen_d  = val_seen_q;
		remain_d    = remain_q;
		cls_d       = cls_q;
		err_d       = err_q;

		res               = '0;
		res.out_byte      = in_byte;
		res.field_kind    = KIND_IGNORED;
		res.parse_done    = (phase_q == PH_DONE) && (err_q == ERR_NONE);

		if (err_q == ERR_NONE && phase_q != PH_DONE) begin
			res.element_index = 32'(el_seen_q);
			unique case (phase_q)
				PH_NAME: begin
					res.field_kind = KIND_NAME;
					remain_d       = rem_dec;
					if (rem_dec == 32'd0) begin
						res.field_end = 1'b1;
						phase_d       = PH_TYPE;
					end
				end
				PH_VALUE: begin
					res.field_kind  = (cls_q == CLS_STR) ? KIND_STRBYTE : KIND_DATABYTE;
					res.value_index = 32'(val_seen_q);
					remain_d        = rem_dec;
					if (rem_dec == 32'd0) begin
						res.field_end = 1'b1;
						fin           = 1'b1;
					end
				end
				default: begin
					// word fields: assemble one byte
					unique case (phase_q)
						PH_COUNT:    res.field_kind = KIND_COUNT;
						PH_NAMELEN:  res.field_kind = KIND_NAMELEN;
						PH_TYPE:     res.field_kind = KIND_TYPE;
						PH_VALCOUNT: res.field_kind = KIND_VALCOUNT;
						PH_INT:      res.field_kind = KIND_INT;
						default:     res.field_kind = KIND_VALLEN;
					endcase
					if (phase_q == PH_INT || phase_q == PH_VALLEN) begin
						res.value_index = 32'(val_seen_q);
					end
					if (pos_q == 2'd3) begin
						pos_d          = 2'd0;
						shift_d        = 32'd0;
						res.word_ready = 1'b1;
						res.word_value = w;
						unique case (phase_q)
							PH_COUNT: begin
								if (w == 32'd0) begin
									err_d = ERR_ZERO_COUNT;
								end else if ({1'b0, w} > CNT_CAP ||
										(cfg.max_elements != 32'd0 && cfg.max_elements < w)) begin
									err_d = ERR_OVER_LIMIT;
								end else begin
									el_total_d = COUNT_BITS'(w);
									el_seen_d  = '0;
									phase_d    = PH_NAMELEN;
								end
							end
							PH_NAMELEN: begin
								if (w == 32'd0) begin
									phase_d = PH_TYPE;
								end else begin
									remain_d = w;
									phase_d  = PH_NAME;
								end
							end
							PH_TYPE: begin
								if (w == cfg.int_type_code)       cls_d = CLS_INT;
								else if (w == cfg.str_type_code)  cls_d = CLS_STR;
								else if (w == cfg.data_type_code) cls_d = CLS_DATA;
								else                              cls_d = CLS_UNKNOWN;
								phase_d = PH_VALCOUNT;
							end
							PH_VALCOUNT: begin
								if (w == 32'd0) begin
									err_d = ERR_ZERO_VALUES;
								end else if (cls_q == CLS_UNKNOWN) begin
									err_d = ERR_UNKNOWN_TYPE;
								end else if ({1'b0, w} > CNT_CAP) begin
									err_d = ERR_OVER_LIMIT;
								end else begin
									val_total_d = COUNT_BITS'(w);
									val_seen_d  = '0;
									phase_d     = (cls_q == CLS_INT) ? PH_INT : PH_VALLEN;
								end
							end
							PH_INT: begin
								res.field_end = 1'b1;
								fin           = 1'b1;
							end
							default: begin
								// value length; an empty value ends here
								if (w == 32'd0) begin
									res.field_end = 1'b1;
									fin           = 1'b1;
								end else begin
									remain_d = w;
									phase_d  = PH_VALUE;
								end
							end
						endcase
					end else begin
						pos_d   = pos_q + 2'd1;
						shift_d = w;
					end
				end
			endcase

			// value completed: advance value and element counters
			if (fin) begin
				if (vs_inc == val_total_q) begin
					res.element_end = 1'b1;
					val_seen_d      = '0;
					el_seen_d       = es_inc;
					if (es_inc == el_total_q) begin
						phase_d        = PH_DONE;
						res.parse_done = 1'b1;
					end else begin
						phase_d = PH_NAMELEN;
					end
				end else begin
					val_seen_d = vs_inc;
					phase_d    = (cls_q == CLS_INT) ? PH_INT : PH_VALLEN;
				end
			end
		end
		res.error_code = err_d;
	end

	// parse state, updated once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			pos_q       <= 2'd0;
			shift_q     <= 32'd0;
			el_total_q  <= '0;
			el_seen_q   <= '0;
			val_total_q <= '0;
			val_seen_q  <= '0;
			remain_q    <= 32'd0;
			cls_q       <= CLS_INT;
			err_q       <= ERR_NONE;
		end else if (step) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			shift_q     <= shift_d;
			el_total_q  <= el_total_d;
			el_seen_q   <= el_seen_d;
			val_total_q <= val_total_d;
			val_seen_q  <= val_seen_d;
			remain_q    <= remain_d;
			cls_q       <= cls_d;
			err_q       <= err_d;
		end
	end

endmodule

FILE: rtl/tlv_pack_stream_parser_unit.sv
`timescale 1ns / 1ps
// top level of the packed element stream parser
//
// Usage:
//   s_* carries the packed stream, one byte per beat in s_tdata. Each input
//   beat yields exactly one result beat on m_*: the byte itself, its field
//   kind in m_tuser and the word, index, end and error tags in m_tdata.
//   cfg_* writes the five configuration registers (cfg_ready is always
//   high); write them only while no beat is in flight.
// Path: an accepted byte is registered in the input stage; its result is
//   registered in the output stage and presented on m_tvalid.
// Throughput: one byte per cycle while m_tready is high; the parse state
//   is updated by the core's next-state logic, so beats stream back to back.
// Reset: arst_n clears the parse state to the element count phase, clears
//   the sticky error, empties both stages and loads the register defaults.
// Stall: while m_tready is low the result is held in the output register;
//   the input stage holds one more byte, then s_tready drops until the
//   output register drains.
module tlv_pack_stream_parser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // in_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_byte, word_ready, word_value, element_index, value_index,
	// field_end, element_end, parse_done, error_code, zero pad
	output logic [tlvp_pkg::OUT_W-1:0]      m_tdata,
	output logic [3:0]                      m_tuser,   // field_kind
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tlvp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import tlvp_pkg::*;

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       advance;

	assign cfg_ready = 1'b1;

	tlvp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a byte moves on when the output register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	tlvp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	// pack the result beat
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.field_kind;
	always_comb begin
		m_tdata                       = '0;
		m_tdata[POS_BYTE +: 8]        = res_s2.out_byte;
		m_tdata[POS_WRDY]             = res_s2.word_ready;
		m_tdata[POS_WVAL +: 32]       = res_s2.word_value;
		m_tdata[POS_EIDX +: 32]       = res_s2.element_index;
		m_tdata[POS_VIDX +: 32]       = res_s2.value_index;
		m_tdata[POS_FEND]             = res_s2.field_end;
		m_tdata[POS_EEND]             = res_s2.element_end;
		m_tdata[POS_DONE]             = res_s2.parse_done;
		m_tdata[POS_ERR +: 3]         = res_s2.error_code;
	end

endmodule

FILE: rtl/tlvp_checker.sv
`timescale 1ns / 1ps
// port-level checks on the parser result stream, bound to the top level
module tlvp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [tlvp_pkg::OUT_W-1:0] m_tdata,
	input logic [3:0]                 m_tuser
);
	import tlvp_pkg::*;

	logic       out_beat;
	logic [2:0] err;
	logic       seen_q;
	logic [2:0] last_err_q;
	logic       last_done_q;

	assign out_beat = m_tvalid && m_tready;
	assign err      = m_tdata[POS_ERR +: 3];

	// remember what the previous result beat showed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_err_q  <= ERR_NONE;
			last_done_q <= 1'b0;
		end else if (out_beat) begin
			seen_q      <= 1'b1;
			last_err_q  <= err;
			last_done_q <= m_tdata[POS_DONE];
		end
	end

	// an error, once shown, stays on every later beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_q && last_err_q != ERR_NONE |-> err == last_err_q)
		else $error("error code changed after being raised");

	// a finished parse stays finished
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_q && last_done_q |-> m_tdata[POS_DONE])
		else $error("parse_done dropped");

	// ignored bytes carry no tags
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_tuser == KIND_IGNORED |->
			!m_tdata[POS_WRDY] && !m_tdata[POS_FEND] && !m_tdata[POS_EEND])
		else $error("ignored byte carries tags");

	// words only complete on word fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_tdata[POS_WRDY] |->
			m_tuser == KIND_COUNT || m_tuser == KIND_NAMELEN || m_tuser == KIND_TYPE ||
			m_tuser == KIND_VALCOUNT || m_tuser == KIND_INT || m_tuser == KIND_VALLEN)
		else $error("word completed on a byte field");

	// an element ends only where a value ends
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_tdata[POS_EEND] |-> m_tdata[POS_FEND])
		else $error("element end without field end");

endmodule

bind tlv_pack_stream_parser_unit tlvp_checker u_tlvp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: test/tlvp_stream_checker.sv
`timescale 1ns / 1ps
// scoreboard for the packed element stream parser: tracks the parse and checks each result beat
module tlvp_stream_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // in_byte
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// out_byte, word_ready, word_value, element_index, value_index,
	// field_end, element_end, parse_done, error_code, zero pad
	input  logic [tlvp_pkg::OUT_W-1:0]     m_tdata,
	input  logic [3:0]                     m_tuser,   // field_kind
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tlvp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             results_seen
);
	import tlvp_pkg::*;

	localparam logic [31:0] CAP32 = CNT_CAP[31:0];

	typedef enum logic [3:0] {
		ST_COUNT, ST_NAMELEN, ST_NAME, ST_TYPE, ST_VALCOUNT,
		ST_INT, ST_VALLEN, ST_VALUE, ST_DONE
	} stage_t;

	typedef enum logic [1:0] {EL_INT, EL_STR, EL_DATA, EL_UNKNOWN} el_class_t;

	// register copy and parse state as the block should hold them
	cfg_t        regs;
	stage_t      stage;
	logic [1:0]  byte_pos;
	logic [31:0] shift_reg;
	logic [31:0] elem_total;
	logic [31:0] elem_seen;
	logic [31:0] val_total;
	logic [31:0] val_seen;
	logic [31:0] bytes_left;
	el_class_t   el_class;
	err_t        err;

	res_t expected_tags[$];
	res_t want;
	res_t got;
	int   mismatches;
	int   compared;

	// one value done: step value and element counters, returns {element_end, parse_done}
	function automatic logic [1:0] close_value();
		logic eend;
		logic done;
		eend = 1'b0;
		done = 1'b0;
		val_seen = (val_seen + 32'd1) & CAP32;
		if (val_seen == val_total) begin
			eend = 1'b1;
			val_seen = '0;
			elem_seen = (elem_seen + 32'd1) & CAP32;
			if (elem_seen == elem_total) begin
				stage = ST_DONE;
				done = 1'b1;
			end else begin
				stage = ST_NAMELEN;
			end
		end else if (el_class == EL_INT) begin
			stage = ST_INT;
		end else begin
			stage = ST_VALLEN;
		end
		return {eend, done};
	endfunction

	// tags of one stream byte, advancing the parse state
	function automatic res_t parse_byte(input logic [7:0] b);
		res_t r;
		logic [31:0] w;
		r = '0;
		r.out_byte = b;
		r.field_kind = KIND_IGNORED;
		r.parse_done = (stage == ST_DONE) && (err == ERR_NONE);
		if (err == ERR_NONE && stage != ST_DONE) begin
			r.element_index = elem_seen;
			if (stage == ST_NAME) begin
				r.field_kind = KIND_NAME;
				bytes_left = bytes_left - 32'd1;
				if (bytes_left == 0) begin
					r.field_end = 1'b1;
					stage = ST_TYPE;
				end
			end else if (stage == ST_VALUE) begin
				if (el_class == EL_STR)
					r.field_kind = KIND_STRBYTE;
				else
					r.field_kind = KIND_DATABYTE;
				r.value_index = val_seen;
				bytes_left = bytes_left - 32'd1;
				if (bytes_left == 0) begin
					r.field_end = 1'b1;
					{r.element_end, r.parse_done} = close_value();
				end
			end else begin
				case (stage)
					ST_COUNT:    r.field_kind = KIND_COUNT;
					ST_NAMELEN:  r.field_kind = KIND_NAMELEN;
					ST_TYPE:     r.field_kind = KIND_TYPE;
					ST_VALCOUNT: r.field_kind = KIND_VALCOUNT;
					ST_INT: begin
						r.field_kind = KIND_INT;
						r.value_index = val_seen;
					end
					default: begin
						r.field_kind = KIND_VALLEN;
						r.value_index = val_seen;
					end
				endcase
				// word assembly in the current byte order
				if (regs.big_endian_words)
					shift_reg = {shift_reg[23:0], b};
				else
					shift_reg = {b, shift_reg[31:8]};
				if (byte_pos == 2'd3) begin
					w = shift_reg;
					byte_pos = '0;
					shift_reg = '0;
					r.word_ready = 1'b1;
					r.word_value = w;
					case (stage)
						ST_COUNT: begin
							if (w == 0)
								err = ERR_ZERO_COUNT;
							else if ({1'b0, w} > CNT_CAP ||
									(regs.max_elements != 0 && regs.max_elements < w))
								err = ERR_OVER_LIMIT;
							else begin
								elem_total = w;
								elem_seen = '0;
								stage = ST_NAMELEN;
							end
						end
						ST_NAMELEN: begin
							if (w == 0) begin
								stage = ST_TYPE;
							end else begin
								bytes_left = w;
								stage = ST_NAME;
							end
						end
						ST_TYPE: begin
							// codes tried as int, then string, then data
							if (w == regs.int_type_code)
								el_class = EL_INT;
							else if (w == regs.str_type_code)
								el_class = EL_STR;
							else if (w == regs.data_type_code)
								el_class = EL_DATA;
							else
								el_class = EL_UNKNOWN;
							stage = ST_VALCOUNT;
						end
						ST_VALCOUNT: begin
							if (w == 0)
								err = ERR_ZERO_VALUES;
							else if (el_class == EL_UNKNOWN)
								err = ERR_UNKNOWN_TYPE;
							else if ({1'b0, w} > CNT_CAP)
								err = ERR_OVER_LIMIT;
							else begin
								val_total = w;
								val_seen = '0;
								if (el_class == EL_INT)
									stage = ST_INT;
								else
									stage = ST_VALLEN;
							end
						end
						ST_INT: begin
							r.field_end = 1'b1;
							{r.element_end, r.parse_done} = close_value();
						end
						default: begin
							// empty value ends on its length word
							if (w == 0) begin
								r.field_end = 1'b1;
								{r.element_end, r.parse_done} = close_value();
							end else begin
								bytes_left = w;
								stage = ST_VALUE;
							end
						end
					endcase
				end else begin
					byte_pos = byte_pos + 2'd1;
				end
			end
		end
		r.error_code = err;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// watch the three channels; results are checked before new bytes are predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.max_elements = '0;
			regs.int_type_code = 32'd0;
			regs.str_type_code = 32'd1;
			regs.data_type_code = 32'd2;
			regs.big_endian_words = 1'b0;
			stage = ST_COUNT;
			byte_pos = '0;
			shift_reg = '0;
			elem_total = '0;
			elem_seen = '0;
			val_total = '0;
			val_seen = '0;
			bytes_left = '0;
			el_class = EL_INT;
			err = ERR_NONE;
			expected_tags.delete();
			mismatches = 0;
			compared = 0;
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_ELEMENTS:   regs.max_elements = cfg_data;
					REG_INT_TYPE_CODE:  regs.int_type_code = cfg_data;
					REG_STR_TYPE_CODE:  regs.str_type_code = cfg_data;
					REG_DATA_TYPE_CODE: regs.data_type_code = cfg_data;
					REG_BIG_ENDIAN:     regs.big_endian_words = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				compared++;
				if (expected_tags.size() == 0) begin
					$error("result beat with nothing expected, byte 0x%0h", m_tdata[POS_BYTE +: 8]);
					mismatches++;
				end else begin
					want = expected_tags.pop_front();
					got.out_byte      = m_tdata[POS_BYTE +: 8];
					got.field_kind    = kind_t'(m_tuser);
					got.word_ready    = m_tdata[POS_WRDY];
					got.word_value    = m_tdata[POS_WVAL +: 32];
					got.element_index = m_tdata[POS_EIDX +: 32];
					got.value_index   = m_tdata[POS_VIDX +: 32];
					got.field_end     = m_tdata[POS_FEND];
					got.element_end   = m_tdata[POS_EEND];
					got.parse_done    = m_tdata[POS_DONE];
					got.error_code    = err_t'(m_tdata[POS_ERR +: 3]);
					check_field("out_byte", want.out_byte, got.out_byte);
					check_field("field_kind", want.field_kind, got.field_kind);
					check_field("word_ready", want.word_ready, got.word_ready);
					check_field("word_value", want.word_value, got.word_value);
					check_field("element_index", want.element_index, got.element_index);
					check_field("value_index", want.value_index, got.value_index);
					check_field("field_end", want.field_end, got.field_end);
					check_field("element_end", want.element_end, got.element_end);
					check_field("parse_done", want.parse_done, got.parse_done);
					check_field("error_code", want.error_code, got.error_code);
				end
			end
			if (s_tvalid && s_tready)
				expected_tags.push_back(parse_byte(s_tdata));
			fail_count <= mismatches;
			pending <= expected_tags.size();
			results_seen <= compared;
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// testbench top: streams packed element data into the parser and gives the verdict
module tb_top;
	import tlvp_pkg::*;

	typedef enum {END_DONE, END_ZERO_VALUES, END_UNKNOWN_TYPE, END_ZERO_COUNT,
		END_OVER_LIMIT} ending_t;
	typedef enum {EK_INT, EK_STR, EK_DATA} el_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic [3:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_ELEMENTS;
	logic [31:0]           cfg_data = '0;

	int fail_count;
	int pending;
	int results_seen;

	// register values as last written, used to build well-formed streams
	cfg_t    reg_shadow;
	ending_t ending;
	string   ending_text;
	int      bytes_sent;
	int      elements_sent;
	int      writes_done;
	int      quiet_left;

	always #5 clk = ~clk;

	tlv_pack_stream_parser_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tlvp_stream_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	// register values biased to the extremes
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 32'h0000_0000;
		else if (r == 1)
			return 32'hFFFF_FFFF;
		else
			return $urandom;
	endfunction

	// output side stalls
	always begin : ready_gen
		int hold;
		int stall;
		if ($urandom_range(0, 99) < 5)
			hold = $urandom_range(50, 200);
		else
			hold = $urandom_range(1, 6);
		repeat (hold) @(posedge clk);
		stall = gap_len();
		if (stall > 0) begin
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
			m_tready <= 1'b1;
		end
	end

	// one stream beat, after a random gap
	task automatic send_byte(input logic [7:0] b);
		int gap;
		cfg_valid <= 1'b0;
		if (quiet_left > 0) begin
			gap = 0;
			quiet_left--;
		end else begin
			gap = gap_len();
			if ($urandom_range(0, 99) < 2)
				quiet_left = $urandom_range(30, 150);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) begin
			if (reg_shadow.big_endian_words)
				send_byte(w[31 - 8 * i -: 8]);
			else
				send_byte(w[8 * i +: 8]);
		end
	endtask

	// stop sending and let every outstanding result drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		case (idx)
			REG_MAX_ELEMENTS:   reg_shadow.max_elements = val;
			REG_INT_TYPE_CODE:  reg_shadow.int_type_code = val;
			REG_STR_TYPE_CODE:  reg_shadow.str_type_code = val;
			REG_DATA_TYPE_CODE: reg_shadow.data_type_code = val;
			default:            reg_shadow.big_endian_words = val[0];
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		writes_done++;
	endtask

	task automatic shuffle_regs();
		int n;
		reg_idx_t idx;
		wait_idle();
		n = $urandom_range(1, 3);
		repeat (n) begin
			idx = reg_idx_t'($urandom_range(0, 4));
			cfg_write(idx, pick_word());
		end
	endtask

	// class the block will give a type word, int code first
	function automatic el_kind_t kind_of(input logic [31:0] code);
		if (code == reg_shadow.int_type_code)
			return EK_INT;
		else if (code == reg_shadow.str_type_code)
			return EK_STR;
		else
			return EK_DATA;
	endfunction

	// one element with random content; a fault ends it at the value count word
	task automatic send_element(input ending_t fault);
		int name_len;
		int n_vals;
		int len;
		int k;
		int r;
		logic [31:0] tcode;
		el_kind_t kind;
		r = $urandom_range(0, 99);
		if (r < 30)
			name_len = 0;
		else if (r < 90)
			name_len = $urandom_range(1, 8);
		else
			name_len = $urandom_range(9, 40);
		send_word(name_len);
		repeat (name_len) send_byte(8'($urandom_range(0, 255)));
		r = $urandom_range(0, 2);
		if (r == 0)
			tcode = reg_shadow.int_type_code;
		else if (r == 1)
			tcode = reg_shadow.str_type_code;
		else
			tcode = reg_shadow.data_type_code;
		kind = kind_of(tcode);
		if (fault == END_UNKNOWN_TYPE) begin
			tcode = $urandom;
			while (tcode == reg_shadow.int_type_code || tcode == reg_shadow.str_type_code ||
					tcode == reg_shadow.data_type_code)
				tcode = $urandom;
		end
		send_word(tcode);
		r = $urandom_range(0, 99);
		if (r < 70)
			n_vals = $urandom_range(1, 3);
		else if (r < 95)
			n_vals = $urandom_range(4, 8);
		else
			n_vals = $urandom_range(9, 24);
		if (fault == END_ZERO_VALUES)
			n_vals = 0;
		send_word(n_vals);
		elements_sent++;
		if (fault != END_DONE)
			return;
		repeat (n_vals) begin
			if (kind == EK_INT) begin
				// now and then flip the byte order partway through an integer
				if ($urandom_range(0, 19) == 0) begin
					k = $urandom_range(1, 3);
					repeat (k) send_byte(8'($urandom_range(0, 255)));
					wait_idle();
					cfg_write(REG_BIG_ENDIAN, {31'd0, ~reg_shadow.big_endian_words});
					repeat (4 - k) send_byte(8'($urandom_range(0, 255)));
				end else begin
					repeat (4) send_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				r = $urandom_range(0, 99);
				if (r < 25)
					len = 0;
				else if (r < 85)
					len = $urandom_range(1, 8);
				else
					len = $urandom_range(9, 20);
				send_word(len);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int r;
		int n_elems;
		int fault_at;
		int noise_len;
		logic [31:0] max_el;
		bytes_sent = 0;
		elements_sent = 0;
		writes_done = 0;
		quiet_left = 0;
		reg_shadow = '0;

		// how this run's stream ends
		r = $urandom_range(0, 99);
		if (r < 40)
			ending = END_DONE;
		else if (r < 65)
			ending = END_ZERO_VALUES;
		else if (r < 90)
			ending = END_UNKNOWN_TYPE;
		else if (r < 95)
			ending = END_ZERO_COUNT;
		else
			ending = END_OVER_LIMIT;
		n_elems = $urandom_range(35, 39);
		fault_at = n_elems;
		if (ending == END_ZERO_VALUES || ending == END_UNKNOWN_TYPE)
			fault_at = $urandom_range(n_elems / 2, n_elems - 1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every register once, with distinct type codes, int and string at the extremes
		if (ending == END_OVER_LIMIT) begin
			max_el = $urandom_range(1, n_elems - 1);
		end else begin
			r = $urandom_range(0, 3);
			if (r == 0)
				max_el = 32'd0;
			else if (r == 1)
				max_el = n_elems;
			else if (r == 2)
				max_el = 32'hFFFF_FFFF;
			else
				max_el = $urandom_range(n_elems, 32'h7FFF_FFFF);
		end
		cfg_write(REG_MAX_ELEMENTS, max_el);
		cfg_write(REG_INT_TYPE_CODE, 32'hFFFF_FFFF);
		cfg_write(REG_STR_TYPE_CODE, 32'h0000_0000);
		cfg_write(REG_DATA_TYPE_CODE, $urandom_range(1, 32'h7FFF_FFFF));
		cfg_write(REG_BIG_ENDIAN, $urandom_range(0, 1));

		send_word((ending == END_ZERO_COUNT) ? 32'd0 : n_elems);

		if (ending != END_ZERO_COUNT && ending != END_OVER_LIMIT) begin
			// unnamed integer element holding the largest word
			send_word(32'd0);
			send_word(reg_shadow.int_type_code);
			send_word(32'd1);
			send_word(32'hFFFF_FFFF);
			elements_sent++;
			// data element: extreme name bytes, an empty value, then a one-byte value
			send_word(32'd2);
			send_byte(8'h00);
			send_byte(8'hFF);
			send_word(reg_shadow.data_type_code);
			send_word(32'd2);
			send_word(32'd0);
			send_word(32'd1);
			send_byte(8'h00);
			elements_sent++;

			for (int e = 2; e < n_elems; e++) begin
				if ($urandom_range(0, 99) < 15)
					shuffle_regs();
				if (e == fault_at) begin
					send_element(ending);
					break;
				end
				send_element(END_DONE);
			end
		end

		// bytes after the end of the parse or after an error are ignored;
		// short streams are topped up so every run carries a similar load
		noise_len = $urandom_range(40, 80);
		if (bytes_sent + noise_len < 1700)
			noise_len = 1700 - bytes_sent;
		for (int i = 0; i < noise_len; i++) begin
			if (i == noise_len / 2)
				shuffle_regs();
			send_byte(8'($urandom_range(0, 255)));
		end

		wait_idle();
		repeat (4) @(posedge clk);

		case (ending)
			END_DONE:         ending_text = "complete parse";
			END_ZERO_VALUES:  ending_text = "zero value count error";
			END_UNKNOWN_TYPE: ending_text = "unknown type error";
			END_ZERO_COUNT:   ending_text = "zero element count error";
			default:          ending_text = "element count over limit";
		endcase
		$display("streamed %0d bytes over %0d elements, %0d register writes, ending: %s",
			bytes_sent, elements_sent, writes_done, ending_text);
		$display("%0d result beats compared, %0d mismatches", results_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
rtl/tlvp_pkg.sv
rtl/tlvp_cfg_regs.sv
rtl/tlvp_parse_core.sv
rtl/tlv_pack_stream_parser_unit.sv
rtl/tlvp_checker.sv
test/tlvp_stream_checker.sv
test/tb_top.sv
